// ===== rtl/lcsl_pkg.sv =====
// Shared types and constants for the longest common substring length unit.
`default_nettype none

package lcsl_pkg;

	localparam int unsigned PATTERN_CAPACITY = 128;
	localparam int unsigned CHAR_W           = 8;
	localparam int unsigned LEN_W            = 8;
	localparam int unsigned ACTION_W         = 2;
	localparam int unsigned S_TDATA_W        = 16;
	localparam int unsigned M_TDATA_W        = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_EOL    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic append;
		logic clear_pattern;
		logic clear_row;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic last_issue;
		logic out_valid;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/lcsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcsl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcsl_ctrl.sv =====
// Controller state machine: input handshake, command decode and sweep sequencing.
`default_nettype none

module lcsl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire lcsl_pkg::action_t action,
	input  wire logic             m_tready,
	input  wire lcsl_pkg::status_t status,
	output lcsl_pkg::cmd_t        cmd
);

	lcsl_pkg::state_t state_q;
	lcsl_pkg::state_t state_next;
	logic             fire;

	assign s_tready = (state_q == lcsl_pkg::ST_IDLE)
		&& ((action != lcsl_pkg::ACT_EOL) || !status.out_valid || m_tready);
	assign fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			lcsl_pkg::ST_IDLE: begin
				if (fire && (action == lcsl_pkg::ACT_TEXT) && !status.count_zero) begin
					state_next = lcsl_pkg::ST_SWEEP;
				end
			end
			lcsl_pkg::ST_SWEEP: begin
				if (status.last_issue) begin
					state_next = lcsl_pkg::ST_FLUSH;
				end
			end
			lcsl_pkg::ST_FLUSH: begin
				state_next = lcsl_pkg::ST_IDLE;
			end
			default: begin
				state_next = lcsl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd               = '0;
		cmd.issue         = (state_q == lcsl_pkg::ST_SWEEP);
		cmd.start         = fire && (action == lcsl_pkg::ACT_TEXT) && !status.count_zero;
		cmd.append        = fire && (action == lcsl_pkg::ACT_APPEND);
		cmd.clear_pattern = fire && (action == lcsl_pkg::ACT_CLEAR);
		cmd.clear_row     = fire && ((action == lcsl_pkg::ACT_CLEAR)
			|| (action == lcsl_pkg::ACT_EOL));
		cmd.emit          = fire && (action == lcsl_pkg::ACT_EOL);
	end

endmodule

`default_nettype wire

// ===== rtl/lcsl_dp.sv =====
// Datapath: pattern and run-length memories, column sweep, best tracking and result register.
`default_nettype none

module lcsl_dp #(
	parameter int unsigned PATTERN_CAPACITY = lcsl_pkg::PATTERN_CAPACITY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcsl_pkg::cmd_t                cmd,
	input  wire logic [lcsl_pkg::CHAR_W-1:0]   char_value,
	output lcsl_pkg::status_t                  status,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [lcsl_pkg::LEN_W-1:0]    match_length
);

	localparam int unsigned AW = (PATTERN_CAPACITY > 1) ? $clog2(PATTERN_CAPACITY) : 1;
	localparam int unsigned CW = $clog2(PATTERN_CAPACITY + 1);
	localparam int unsigned LW = lcsl_pkg::LEN_W;

	logic [CW-1:0]                  count_q;
	logic                           count_full;
	logic [AW-1:0]                  count_idx;
	logic [lcsl_pkg::CHAR_W-1:0]    char_q;
	logic [AW-1:0]                  k_q;
	logic                           valid_s1;
	logic [AW-1:0]                  k_s1;
	logic                           rv_s1;
	logic [PATTERN_CAPACITY-1:0]    run_valid_q;
	logic [LW-1:0]                  prev_q;
	logic [LW-1:0]                  best_q;
	logic                           out_valid_q;
	logic [LW-1:0]                  out_len_q;
	logic [lcsl_pkg::CHAR_W-1:0]    pat_rdata;
	logic [LW-1:0]                  run_rdata;
	logic [LW-1:0]                  run_old;
	logic [LW-1:0]                  run_new;
	logic                           do_append;

	assign count_full = (count_q == CW'(PATTERN_CAPACITY));
	assign count_idx  = count_q[AW-1:0];
	assign do_append  = cmd.append && !count_full;

	assign run_old = rv_s1 ? run_rdata : '0;
	assign run_new = (pat_rdata != char_q) ? '0
		: ((prev_q == {LW{1'b1}}) ? prev_q : prev_q + LW'(1));

	assign status.count_zero = (count_q == '0);
	assign status.last_issue = cmd.issue && (CW'(k_q) == count_q - CW'(1));
	assign status.out_valid  = out_valid_q;

	assign m_tvalid     = out_valid_q;
	assign match_length = out_len_q;

	lcsl_ram #(
		.WIDTH (lcsl_pkg::CHAR_W),
		.DEPTH (PATTERN_CAPACITY)
	) u_pattern_ram (
		.clk   (clk),
		.we    (do_append),
		.waddr (count_idx),
		.wdata (char_value),
		.re    (cmd.issue),
		.raddr (k_q),
		.rdata (pat_rdata)
	);

	lcsl_ram #(
		.WIDTH (LW),
		.DEPTH (PATTERN_CAPACITY)
	) u_run_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (k_s1),
		.wdata (run_new),
		.re    (cmd.issue),
		.raddr (k_q),
		.rdata (run_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			run_valid_q <= '0;
			best_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_pattern) begin
				count_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + CW'(1);
			end

			if (cmd.clear_row) begin
				run_valid_q <= '0;
			end else begin
				if (do_append) begin
					run_valid_q[count_idx] <= 1'b0;
				end
				if (valid_s1) begin
					run_valid_q[k_s1] <= 1'b1;
				end
			end

			if (cmd.clear_row) begin
				best_q <= '0;
			end else if (valid_s1 && (run_new > best_q)) begin
				best_q <= run_new;
			end

			valid_s1 <= cmd.issue;

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			char_q <= char_value;
			k_q    <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.issue) begin
				k_q <= k_q + AW'(1);
			end
			if (valid_s1) begin
				prev_q <= run_old;
			end
		end
		if (cmd.issue) begin
			k_s1  <= k_q;
			rv_s1 <= run_valid_q[k_q];
		end
		if (cmd.emit) begin
			out_len_q <= best_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/longest_common_substring_length_unit.sv =====
// Top level of the longest common substring length unit.
`default_nettype none

// Holds a pattern of up to PATTERN_CAPACITY bytes and reports, for each text
// line, the length of the longest substring it shares with the pattern. Input
// items carry an action (clear pattern, append pattern byte, text byte, end of
// line) and a byte; an end-of-line item yields one result item and restarts
// the line. A text byte starts a sweep: the row of run lengths and the pattern
// live in single-read-port RAMs, so the sweep reads one pattern column per
// cycle, then drains the read stage in ST_FLUSH; no new item is accepted until
// the sweep ends. With an empty pattern a text byte starts no sweep. No
// clearing pass follows reset. A result waits in an output register while
// further non-end-of-line items are accepted.
module longest_common_substring_length_unit #(
	parameter int unsigned PATTERN_CAPACITY = lcsl_pkg::PATTERN_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lcsl_pkg::S_TDATA_W-1:0]    s_tdata,  // action[1:0], char_value[9:2]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [lcsl_pkg::M_TDATA_W-1:0]    m_tdata   // match_length[7:0]
);

	lcsl_pkg::action_t  action;
	lcsl_pkg::cmd_t     cmd;
	lcsl_pkg::status_t  status;
	logic [lcsl_pkg::CHAR_W-1:0] char_value;

	assign action     = lcsl_pkg::action_t'(s_tdata[lcsl_pkg::ACTION_W-1:0]);
	assign char_value = s_tdata[lcsl_pkg::ACTION_W +: lcsl_pkg::CHAR_W];

	lcsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (action),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcsl_dp #(
		.PATTERN_CAPACITY (PATTERN_CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.char_value   (char_value),
		.status       (status),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.match_length (m_tdata)
	);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata <= lcsl_pkg::M_TDATA_W'(PATTERN_CAPACITY)))
		else $error("match length exceeds pattern capacity");

	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("end of line accepted without a result item");

	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (!s_tready && cmd.issue))
		else $error("text byte sweep did not start");

endmodule

`default_nettype wire

// ===== verif/tb_longest_common_substring_length_unit.sv =====
// Testbench for the longest common substring length unit: queued items, predictor, checks.
`timescale 1ns / 100ps

module tb_longest_common_substring_length_unit;

	localparam int ITEM_TARGET    = 1550;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = lcsl_pkg::PATTERN_CAPACITY + 16;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		lcsl_pkg::action_t act;
		logic [7:0]        ch;
	} line_item_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [lcsl_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [lcsl_pkg::M_TDATA_W-1:0]  m_tdata;

	line_item_t  pending_items[$];
	logic [7:0]  expected_lengths[$];
	logic [7:0]  gen_pattern[$];

	logic [7:0]  pat_mem [lcsl_pkg::PATTERN_CAPACITY];
	logic [7:0]  run_len [lcsl_pkg::PATTERN_CAPACITY] = '{default: 8'd0};
	int          pat_count = 0;
	logic [7:0]  best_len  = 8'd0;

	logic        in_taken     = 1'b0;
	int          items_taken  = 0;
	int          total_items  = 1;
	int          mismatches   = 0;
	int          idle_cycles  = 0;
	int          src_idle_pct;
	int          sink_idle_pct;

	longest_common_substring_length_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // action[1:0], char_value[9:2]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)    // match_length[7:0]
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always_comb begin
		case ((items_taken * 3) / total_items)
			0: begin
				src_idle_pct  = 33;
				sink_idle_pct = 78;
			end
			1: begin
				src_idle_pct  = 78;
				sink_idle_pct = 33;
			end
			default: begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
		endcase
	end

	function automatic logic [7:0] pick_char(input logic [7:0] base, input int alpha);
		if (alpha >= 256)
			return 8'($urandom_range(0, 255));
		return 8'(base + $urandom_range(0, alpha - 1));
	endfunction

	task automatic push_item(input lcsl_pkg::action_t act, input logic [7:0] ch);
		line_item_t it;
		it.act = act;
		it.ch  = ch;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic clear_line_state();
		for (int k = 0; k < lcsl_pkg::PATTERN_CAPACITY; k++)
			run_len[k] = 8'd0;
		best_len = 8'd0;
	endtask

	// advance the predicted pattern, run row and best by one accepted item
	task automatic lcs_step(input lcsl_pkg::action_t act, input logic [7:0] ch);
		logic [7:0] run_v;
		logic [7:0] left;
		case (act)
			lcsl_pkg::ACT_CLEAR: begin
				pat_count = 0;
				clear_line_state();
			end
			lcsl_pkg::ACT_APPEND: begin
				if (pat_count < lcsl_pkg::PATTERN_CAPACITY) begin
					pat_mem[pat_count] = ch;
					run_len[pat_count] = 8'd0;
					pat_count++;
				end
			end
			lcsl_pkg::ACT_TEXT: begin
				for (int k = pat_count - 1; k >= 0; k--) begin
					run_v = 8'd0;
					if (pat_mem[k] == ch) begin
						left  = (k == 0) ? 8'd0 : run_len[k - 1];
						run_v = (left == 8'hFF) ? 8'hFF : left + 8'd1;
					end
					run_len[k] = run_v;
					if (run_v > best_len)
						best_len = run_v;
				end
			end
			default: begin
				expected_lengths.insert(expected_lengths.size(), best_len);
				clear_line_state();
			end
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// driver: present items at the falling edge
	always @(negedge clk) begin
		line_item_t it;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					it = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(lcsl_pkg::S_TDATA_W - 10){1'b0}}, it.ch, it.act};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// monitor: check results, then predict from the accepted item
	always @(posedge clk) begin
		logic [7:0] want;
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_lengths.size() == 0) begin
					note_mismatch($sformatf("unexpected match_length %0d", m_tdata));
				end else begin
					want = expected_lengths.pop_front();
					if (m_tdata !== want)
						note_mismatch($sformatf("match_length expected %0d actual %0d",
							want, m_tdata));
				end
			end
			if (s_tvalid && s_tready) begin
				lcs_step(lcsl_pkg::action_t'(s_tdata[1:0]), s_tdata[9:2]);
				items_taken++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int         roll;
		int         plen;
		int         alpha;
		int         tlen;
		int         pos;
		int         r;
		bit         first_seq;
		logic [7:0] base;
		logic [7:0] c;

		// empty pattern, unused fields, extreme bytes
		push_item(lcsl_pkg::ACT_EOL, 8'hFF);
		push_item(lcsl_pkg::ACT_TEXT, 8'h00);
		push_item(lcsl_pkg::ACT_EOL, 8'h00);
		push_item(lcsl_pkg::ACT_APPEND, 8'h00);
		push_item(lcsl_pkg::ACT_APPEND, 8'hFF);
		push_item(lcsl_pkg::ACT_APPEND, 8'hA5);
		push_item(lcsl_pkg::ACT_TEXT, 8'h00);
		push_item(lcsl_pkg::ACT_TEXT, 8'hFF);
		push_item(lcsl_pkg::ACT_TEXT, 8'hA5);
		// append mid-line, then extend the run
		push_item(lcsl_pkg::ACT_APPEND, 8'h5A);
		push_item(lcsl_pkg::ACT_TEXT, 8'h5A);
		push_item(lcsl_pkg::ACT_EOL, 8'hAA);
		push_item(lcsl_pkg::ACT_TEXT, 8'hFF);
		push_item(lcsl_pkg::ACT_TEXT, 8'hA5);
		push_item(lcsl_pkg::ACT_TEXT, 8'h00);
		// clear mid-line drops the line in progress
		push_item(lcsl_pkg::ACT_CLEAR, 8'h3C);
		push_item(lcsl_pkg::ACT_TEXT, 8'hFF);
		push_item(lcsl_pkg::ACT_EOL, 8'h00);
		push_item(lcsl_pkg::ACT_APPEND, 8'h7E);
		push_item(lcsl_pkg::ACT_APPEND, 8'h81);
		push_item(lcsl_pkg::ACT_TEXT, 8'h81);
		push_item(lcsl_pkg::ACT_EOL, 8'h55);

		first_seq = 1'b1;
		while (pending_items.size() < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 7 && !first_seq) begin
				repeat ($urandom_range(1, 6))
					push_item(lcsl_pkg::action_t'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				push_item(lcsl_pkg::ACT_CLEAR, 8'($urandom));
				gen_pattern.delete();
				if (first_seq)
					plen = lcsl_pkg::PATTERN_CAPACITY + 2;
				else if (roll < 11)
					plen = $urandom_range(100, lcsl_pkg::PATTERN_CAPACITY + 2);
				else
					plen = $urandom_range(0, 12);
				alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
				base  = 8'($urandom);
				for (int i = 0; i < plen; i++) begin
					c = pick_char(base, alpha);
					if (gen_pattern.size() < lcsl_pkg::PATTERN_CAPACITY)
						gen_pattern.insert(gen_pattern.size(), c);
					push_item(lcsl_pkg::ACT_APPEND, c);
				end
				repeat ($urandom_range(1, 4)) begin
					if (first_seq) begin
						// whole pattern as one line: longest possible run
						foreach (gen_pattern[i])
							push_item(lcsl_pkg::ACT_TEXT, gen_pattern[i]);
						first_seq = 1'b0;
					end else begin
						tlen = (plen > 12) ? $urandom_range(0, 10) : $urandom_range(0, 16);
						pos  = 0;
						for (int i = 0; i < tlen; i++) begin
							r = $urandom_range(0, 3);
							if (r == 0 || gen_pattern.size() == 0) begin
								c = pick_char(base, alpha);
							end else begin
								if (r == 1)
									pos = $urandom_range(0, gen_pattern.size() - 1);
								c = gen_pattern[pos % gen_pattern.size()];
								pos++;
							end
							push_item(lcsl_pkg::ACT_TEXT, c);
							if ($urandom_range(0, 59) == 0) begin
								c = pick_char(base, alpha);
								if (gen_pattern.size() < lcsl_pkg::PATTERN_CAPACITY)
									gen_pattern.insert(gen_pattern.size(), c);
								push_item(lcsl_pkg::ACT_APPEND, c);
							end else if ($urandom_range(0, 89) == 0) begin
								gen_pattern.delete();
								push_item(lcsl_pkg::ACT_CLEAR, 8'($urandom));
							end
						end
					end
					push_item(lcsl_pkg::ACT_EOL, 8'($urandom));
				end
			end
		end
		total_items = pending_items.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_lengths.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_lengths.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lcsl_pkg.sv
rtl/lcsl_ram.sv
rtl/lcsl_ctrl.sv
rtl/lcsl_dp.sv
rtl/longest_common_substring_length_unit.sv
verif/tb_longest_common_substring_length_unit.sv
